// ===== sv/cascaded_segment_byte_fifo_macros.svh =====
// assertion macros shared by the fifo rtl
`ifndef CASCADED_SEGMENT_BYTE_FIFO_MACROS_SVH
`define CASCADED_SEGMENT_BYTE_FIFO_MACROS_SVH

`ifndef ASSERT_OFF
`define CSBF_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("csbf assertion failed");
`define CSBF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("csbf assertion failed");
`else
`define CSBF_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define CSBF_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== sv/csbf_pkg.sv =====
package csbf_pkg;

    localparam int NUM_SEGMENTS_DEF  = 4;
    localparam int SEGMENT_DEPTH_DEF = 256;

    localparam int BYTE_W     = 8;
    localparam int SIZE_W     = 9;
    localparam int SEG_W      = 2;
    localparam int SUM_W      = 11;
    localparam int REQ_W      = 3;
    localparam int MASK_W     = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 9;
    localparam int IN_W       = 16;
    localparam int OUT_W      = 40;

    localparam logic [REQ_W-1:0] REQ_PUSH     = 3'd0;
    localparam logic [REQ_W-1:0] REQ_POP      = 3'd1;
    localparam logic [REQ_W-1:0] REQ_CLEAR    = 3'd2;
    localparam logic [REQ_W-1:0] REQ_SET_FULL = 3'd3;
    localparam logic [REQ_W-1:0] REQ_STATUS   = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_SIZE0  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE1  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE2  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE3  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MASK   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FILLER = 3'd5;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } state_t;

endpackage

// ===== sv/csbf_ram.sv =====
module csbf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/cascaded_segment_byte_fifo.sv =====
// Cascaded segment byte FIFO.
// Requests arrive on the s_ stream: one beat holds a request type, a start
// segment, chain and direction flags and a push byte. Each request returns
// exactly one response beat on the m_ stream with ok, popped byte, serving
// segment and capacity/usage/empty/full over the scope.
// The cfg_ port writes segment sizes, the storage mask and the filler byte;
// writing a size makes that segment full with zeroed pointers. Write it only
// while no request is in flight.
// One request is handled at a time: the idle state picks the segment and
// issues the byte store write or read; the exec state takes the registered
// read data and sums the scope status into the output register, waiting
// there while an earlier response has not yet been taken.
// Reset: state, sizes, counts, pointers, mask and filler clear, then a pass
// writes zeros to all NUM_SEGMENTS * SEGMENT_DEPTH store entries (1024 at
// default sizes), one per cycle; s_tready stays low until the pass ends.
// Stall: the response sits in an output register; a new request is taken
// while it waits, and that request's result is held until m_tready frees it.
`include "cascaded_segment_byte_fifo_macros.svh"

module cascaded_segment_byte_fifo #(
    parameter int NUM_SEGMENTS  = csbf_pkg::NUM_SEGMENTS_DEF,
    parameter int SEGMENT_DEPTH = csbf_pkg::SEGMENT_DEPTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // req_type[2:0], start_segment[4:3], whole_chain[5], walk_down[6],
    // push_byte[14:7], zero pad
    input  logic [csbf_pkg::IN_W-1:0]       s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // ok[0], pop_byte[8:1], served_segment[10:9], scope_capacity[21:11],
    // scope_usage[32:22], scope_empty[33], scope_full[34], zero pad
    output logic [csbf_pkg::OUT_W-1:0]      m_tdata,
    input  logic                            cfg_we,
    input  logic [csbf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [csbf_pkg::CFG_DATA_W-1:0] cfg_data
);

    import csbf_pkg::*;

    localparam int MEM_DEPTH  = NUM_SEGMENTS * SEGMENT_DEPTH;
    localparam int AW         = $clog2(MEM_DEPTH);
    localparam int IW         = $clog2(SEGMENT_DEPTH);
    localparam int PW         = ((IW > SIZE_W) ? IW : SIZE_W) + 1;
    localparam int SIZE_TOP   = (1 << SIZE_W) - 1;
    localparam int SIZE_LIMIT = (SEGMENT_DEPTH < SIZE_TOP) ? SEGMENT_DEPTH : SIZE_TOP;
    localparam logic [SIZE_W-1:0] SIZE_MAX  = SIZE_W'(SIZE_LIMIT);
    localparam logic [SEG_W:0]    NUM_SEG_V = (SEG_W + 1)'(NUM_SEGMENTS);
    localparam logic [AW-1:0]     CLR_LAST  = AW'(MEM_DEPTH - 1);
    localparam logic [AW-1:0]     SEG_SPAN  = AW'(SEGMENT_DEPTH);

    // request fields
    logic [REQ_W-1:0]  req;
    logic [SEG_W-1:0]  start;
    logic              chain;
    logic              down;
    logic [BYTE_W-1:0] push_byte;

    assign req       = s_tdata[2:0];
    assign start     = s_tdata[4:3];
    assign chain     = s_tdata[5];
    assign down      = s_tdata[6];
    assign push_byte = s_tdata[14:7];

    // segment state
    logic [SIZE_W-1:0] size_reg  [NUM_SEGMENTS];
    logic [SIZE_W-1:0] size_next [NUM_SEGMENTS];
    logic [SIZE_W-1:0] count_reg [NUM_SEGMENTS];
    logic [SIZE_W-1:0] count_next[NUM_SEGMENTS];
    logic [IW-1:0]     rd_idx_reg [NUM_SEGMENTS];
    logic [IW-1:0]     rd_idx_next[NUM_SEGMENTS];
    logic [IW-1:0]     wr_idx_reg [NUM_SEGMENTS];
    logic [IW-1:0]     wr_idx_next[NUM_SEGMENTS];
    logic [MASK_W-1:0] mask_reg, mask_next;
    logic [BYTE_W-1:0] filler_reg, filler_next;

    state_t            state_reg, state_next;
    logic [AW-1:0]     clr_addr_reg, clr_addr_next;

    // item in flight
    logic [SEG_W-1:0]  ex_start_reg;
    logic              ex_chain_reg;
    logic              ex_ok_reg;
    logic              ex_pop_reg;
    logic              ex_mem_reg;
    logic [SEG_W-1:0]  ex_served_reg;

    logic              out_valid_reg, out_valid_next;
    logic [OUT_W-1:0]  out_data_reg, out_data_next;

    // control
    logic              accept;
    logic              load_out;
    logic              clr_done;
    logic              start_ok;
    logic              is_push;
    logic              is_pop;
    logic              hit;
    logic [SEG_W-1:0]  sel;
    logic              sel_store;
    logic [IW-1:0]     sel_ptr;
    logic [AW-1:0]     mem_addr;
    logic [SIZE_W-1:0] cfg_size;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [BYTE_W-1:0] ram_wdata;
    logic              ram_re;
    logic [BYTE_W-1:0] ram_rdata;

    // status
    logic [SUM_W-1:0]  cap_sum;
    logic [SUM_W-1:0]  use_sum;
    logic              scope_empty;
    logic              scope_full;
    logic [BYTE_W-1:0] pop_byte;
    logic              count_ok;

    assign accept   = s_tvalid && s_tready;
    assign clr_done = (clr_addr_reg == CLR_LAST);
    assign start_ok = ({1'b0, start} < NUM_SEG_V);
    assign is_push  = (req == REQ_PUSH);
    assign is_pop   = (req == REQ_POP);
    assign cfg_size = (cfg_data > SIZE_MAX) ? SIZE_MAX : cfg_data;

    // first-fit segment choice
    always_comb
    begin
        logic in_scope;
        logic cand;
        hit       = 1'b0;
        sel       = '0;
        sel_store = 1'b0;
        sel_ptr   = '0;
        for (int k = NUM_SEGMENTS - 1; k >= 0; k--)
        begin
            in_scope = (SEG_W'(k) >= start) && (chain || (SEG_W'(k) == start));
            cand = in_scope && (is_push ? (mask_reg[k] && (count_reg[k] < size_reg[k]))
                                        : (count_reg[k] != '0));
            if (cand)
            begin
                hit       = 1'b1;
                sel       = SEG_W'(k);
                sel_store = mask_reg[k];
                sel_ptr   = is_push ? wr_idx_reg[k] : rd_idx_reg[k];
            end
        end
    end

    assign mem_addr = AW'(sel) * SEG_SPAN + AW'(sel_ptr);

    // segment state update
    always_comb
    begin
        logic [PW-1:0] nxt;
        logic          in_walk;
        size_next   = size_reg;
        count_next  = count_reg;
        rd_idx_next = rd_idx_reg;
        wr_idx_next = wr_idx_reg;
        mask_next   = mask_reg;
        filler_next = filler_reg;
        nxt         = '0;
        in_walk     = 1'b0;

        if (cfg_we)
        begin
            unique case (cfg_index) inside
                CFG_SIZE0, CFG_SIZE1, CFG_SIZE2, CFG_SIZE3:
                begin
                    for (int k = 0; k < NUM_SEGMENTS; k++)
                    begin
                        if (cfg_index[SEG_W-1:0] == SEG_W'(k))
                        begin
                            size_next[k]   = cfg_size;
                            count_next[k]  = cfg_size;
                            rd_idx_next[k] = '0;
                            wr_idx_next[k] = '0;
                        end
                    end
                end
                CFG_MASK:   mask_next   = cfg_data[MASK_W-1:0];
                CFG_FILLER: filler_next = cfg_data[BYTE_W-1:0];
                default:    ;
            endcase
        end

        if (accept && start_ok)
        begin
            for (int k = 0; k < NUM_SEGMENTS; k++)
            begin
                if (hit && (sel == SEG_W'(k)) && (is_push || is_pop))
                begin
                    nxt = is_push ? (PW'(wr_idx_reg[k]) + PW'(1))
                                  : (PW'(rd_idx_reg[k]) + PW'(1));
                    if (nxt == PW'(size_reg[k]))
                    begin
                        nxt = '0;
                    end
                    if (is_push)
                    begin
                        wr_idx_next[k] = IW'(nxt);
                        count_next[k]  = count_reg[k] + SIZE_W'(1);
                    end
                    else
                    begin
                        rd_idx_next[k] = IW'(nxt);
                        count_next[k]  = count_reg[k] - SIZE_W'(1);
                    end
                end

                if (!chain)
                begin
                    in_walk = (SEG_W'(k) == start);
                end
                else if (down)
                begin
                    in_walk = (SEG_W'(k) <= start);
                end
                else
                begin
                    in_walk = (SEG_W'(k) >= start);
                end

                if (in_walk && ((req == REQ_CLEAR) || (req == REQ_SET_FULL)))
                begin
                    rd_idx_next[k] = '0;
                    wr_idx_next[k] = '0;
                    count_next[k]  = (req == REQ_SET_FULL) ? size_reg[k] : '0;
                end
            end
        end
    end

    // scope status of the item in flight, after its update
    always_comb
    begin
        logic in_scope;
        cap_sum     = '0;
        use_sum     = '0;
        scope_empty = 1'b1;
        scope_full  = 1'b1;
        for (int k = 0; k < NUM_SEGMENTS; k++)
        begin
            in_scope = (SEG_W'(k) >= ex_start_reg)
                       && (ex_chain_reg || (SEG_W'(k) == ex_start_reg));
            if (in_scope)
            begin
                cap_sum = cap_sum + SUM_W'(size_reg[k]);
                use_sum = use_sum + SUM_W'(count_reg[k]);
                if (count_reg[k] != '0)
                begin
                    scope_empty = 1'b0;
                end
                if (count_reg[k] < size_reg[k])
                begin
                    scope_full = 1'b0;
                end
            end
        end
    end

    assign pop_byte = ex_pop_reg ? (ex_mem_reg ? ram_rdata : filler_reg) : '0;

    // fsm: next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_CLEAR;
        endcase
    end

    // fsm: outputs
    always_comb
    begin
        s_tready  = 1'b0;
        load_out  = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = mem_addr;
        ram_wdata = push_byte;
        ram_re    = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_addr_reg;
                ram_wdata = '0;
            end
            ST_IDLE:
            begin
                s_tready = 1'b1;
                ram_we   = s_tvalid && hit && is_push;
                ram_re   = s_tvalid && hit && is_pop && sel_store;
            end
            ST_EXEC:
            begin
                load_out = !out_valid_reg || m_tready;
            end
            default: ;
        endcase
    end

    assign clr_addr_next = (state_reg == ST_CLEAR && !clr_done) ? clr_addr_reg + AW'(1)
                                                                  : clr_addr_reg;

    assign out_valid_next = load_out ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);
    assign out_data_next  = load_out
        ? {5'b0, scope_full, scope_empty, use_sum, cap_sum, ex_served_reg, pop_byte, ex_ok_reg}
        : out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            out_valid_reg <= 1'b0;
            mask_reg      <= '0;
            filler_reg    <= '0;
            for (int k = 0; k < NUM_SEGMENTS; k++)
            begin
                size_reg[k]   <= '0;
                count_reg[k]  <= '0;
                rd_idx_reg[k] <= '0;
                wr_idx_reg[k] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            out_valid_reg <= out_valid_next;
            mask_reg      <= mask_next;
            filler_reg    <= filler_next;
            size_reg      <= size_next;
            count_reg     <= count_next;
            rd_idx_reg    <= rd_idx_next;
            wr_idx_reg    <= wr_idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        if (accept)
        begin
            ex_start_reg  <= start;
            ex_chain_reg  <= chain;
            ex_ok_reg     <= (is_push || is_pop) ? hit : 1'b1;
            ex_pop_reg    <= is_pop && hit;
            ex_mem_reg    <= sel_store;
            ex_served_reg <= ((is_push || is_pop) && hit) ? sel : '0;
        end
    end

    csbf_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (MEM_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (mem_addr),
        .rdata (ram_rdata)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_comb
    begin
        count_ok = 1'b1;
        for (int k = 0; k < NUM_SEGMENTS; k++)
        begin
            if (count_reg[k] > size_reg[k])
            begin
                count_ok = 1'b0;
            end
        end
    end

    `CSBF_ASSERT_IMPL(a_no_take_in_clear, clk, rst_n, state_reg == ST_CLEAR, !s_tready)
    `CSBF_ASSERT_NEXT(a_accept_to_exec, clk, rst_n, accept, state_reg == ST_EXEC)
    `CSBF_ASSERT_IMPL(a_count_in_size, clk, rst_n, 1'b1, count_ok)
    `CSBF_ASSERT_IMPL(a_fail_is_quiet, clk, rst_n, m_tvalid && !m_tdata[0],
        m_tdata[10:1] == '0)
    `CSBF_ASSERT_IMPL(a_no_write_read, clk, rst_n, ram_we, !ram_re)

endmodule
